[rtl/lsro_pkg.sv]
// ----------------------------------------------------------------------------
// Load/store register-offset unit package
// Operation codes, address map constants, the pipeline control struct and decode helpers.
// ----------------------------------------------------------------------------
package lsro_pkg;

   typedef enum logic [2:0] {
      OP_LDR   = 3'd0,
      OP_LDRB  = 3'd1,
      OP_LDRH  = 3'd2,
      OP_LDRSB = 3'd3,
      OP_LDRSH = 3'd4,
      OP_STR   = 3'd5,
      OP_STRB  = 3'd6,
      OP_STRH  = 3'd7
   } op_type;

   localparam logic [31:0] RAM_BASE      = 32'h2000_0000;
   localparam logic [31:0] BYTE_SIGN_EXT = 32'hFFFF_FF00;
   localparam logic [31:0] HALF_SIGN_EXT = 32'hFFFF_0000;
   localparam logic [1:0]  IO_REGION     = 2'b01;

   typedef struct packed {
      logic       valid;
      logic       io;
      logic       fault;
      logic       is_load;
      op_type     op;
      logic [2:0] size;
      logic [1:0] lane_sel;
   } rd_ctrl_type;

   function automatic logic [2:0] access_size(input op_type op);
      logic [2:0] n;
      unique case (op)
         OP_LDR, OP_STR:             n = 3'd4;
         OP_LDRH, OP_LDRSH, OP_STRH: n = 3'd2;
         default:                    n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic is_store(input op_type op);
      return (op == OP_STR) || (op == OP_STRB) || (op == OP_STRH);
   endfunction

endpackage

[rtl/lsro_lane_ram.sv]
// ----------------------------------------------------------------------------
// Byte lane RAM
// Single-port synchronous byte memory with registered read data.
// ----------------------------------------------------------------------------
module lsro_lane_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wr_data,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/load_store_register_offset_unit_top.sv]
// ----------------------------------------------------------------------------
// Load/store register-offset unit
// A request passes through s1_valid_ff, rd_ctrl_ff and the result register before rsp_strobe.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Each byte lane RAM is read or written once per request, read data registered.
// Reset clears the pipeline valid bits only; RAM contents are undefined until
// written. The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
module load_store_register_offset_unit_top #(
   parameter int RAM_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_base_value,
   input  logic [31:0] req_offset_value,
   input  logic [31:0] req_store_value,
   output logic        rsp_strobe,
   output logic [31:0] rsp_load_value,
   output logic        rsp_io_access,
   output logic        rsp_range_fault
);
   import lsro_pkg::*;

   localparam int LANE_DEPTH = (RAM_BYTES + 3) / 4;
   localparam int ROW_W      = $clog2(LANE_DEPTH);

   // stage 1: address and request
   logic        s1_valid_ff;
   logic [31:0] addr_ff;
   op_type      op_ff;
   logic [2:0]  size_ff;
   logic [31:0] sval_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      addr_ff <= req_base_value + req_offset_value;
      op_ff   <= op_type'(req_operation);
      size_ff <= access_size(op_type'(req_operation));
      sval_ff <= req_store_value;
   end

   // stage 1: decode region and drive lane RAMs
   logic [31:0]      rel;
   logic             s1_io;
   logic             s1_fault;
   logic             s1_store;
   logic [ROW_W-1:0] row_base;
   logic [ROW_W-1:0] row_next;
   logic [ROW_W-1:0] lane_row [4];
   logic             lane_we  [4];
   logic [7:0]       lane_wd  [4];
   logic [7:0]       lane_rd  [4];
   logic [1:0]       lane_idx [4];

   always_comb begin
      rel      = addr_ff - RAM_BASE;
      s1_io    = (addr_ff[31:30] == IO_REGION);
      s1_fault = !s1_io && (({1'b0, rel} + {30'd0, size_ff}) > 33'(RAM_BYTES));
      s1_store = is_store(op_ff);
      row_base = rel[ROW_W+1:2];
      row_next = row_base + ROW_W'(1);
      for (int j = 0; j < 4; j++) begin
         lane_idx[j] = 2'(j) - rel[1:0];
         lane_row[j] = (2'(j) < rel[1:0]) ? row_next : row_base;
         lane_wd[j]  = sval_ff[8*lane_idx[j] +: 8];
         lane_we[j]  = s1_valid_ff && s1_store && !s1_io && !s1_fault
                       && ({1'b0, lane_idx[j]} < size_ff);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      lsro_lane_ram #(
         .DEPTH  (LANE_DEPTH),
         .ADDR_W (ROW_W)
      ) u_lane_ram (
         .clock   (clock),
         .wr_en   (lane_we[g]),
         .addr    (lane_row[g]),
         .wr_data (lane_wd[g]),
         .rd_data (lane_rd[g])
      );
   end

   // stage 2: gather bytes
   rd_ctrl_type rd_ctrl_ff;
   rd_ctrl_type rd_ctrl_in;

   always_comb begin
      rd_ctrl_in.valid    = s1_valid_ff;
      rd_ctrl_in.io       = s1_io;
      rd_ctrl_in.fault    = s1_fault;
      rd_ctrl_in.is_load  = !s1_store;
      rd_ctrl_in.op       = op_ff;
      rd_ctrl_in.size     = size_ff;
      rd_ctrl_in.lane_sel = rel[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctrl_ff.valid <= 1'b0;
      end else begin
         rd_ctrl_ff.valid <= rd_ctrl_in.valid;
      end
      rd_ctrl_ff.io       <= rd_ctrl_in.io;
      rd_ctrl_ff.fault    <= rd_ctrl_in.fault;
      rd_ctrl_ff.is_load  <= rd_ctrl_in.is_load;
      rd_ctrl_ff.op       <= rd_ctrl_in.op;
      rd_ctrl_ff.size     <= rd_ctrl_in.size;
      rd_ctrl_ff.lane_sel <= rd_ctrl_in.lane_sel;
   end

   logic [7:0]  byte_sel [4];
   logic [31:0] raw_value;
   logic [31:0] value_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         byte_sel[i] = lane_rd[rd_ctrl_ff.lane_sel + 2'(i)];
      end
      unique case (rd_ctrl_ff.size)
         3'd4:    raw_value = {byte_sel[3], byte_sel[2], byte_sel[1], byte_sel[0]};
         3'd2:    raw_value = {16'd0, byte_sel[1], byte_sel[0]};
         default: raw_value = {24'd0, byte_sel[0]};
      endcase
      value_in = raw_value;
      if (rd_ctrl_ff.op == OP_LDRSB && raw_value[7]) begin
         value_in = raw_value | BYTE_SIGN_EXT;
      end
      if (rd_ctrl_ff.op == OP_LDRSH && raw_value[15]) begin
         value_in = raw_value | HALF_SIGN_EXT;
      end
      if (!rd_ctrl_ff.is_load || rd_ctrl_ff.io || rd_ctrl_ff.fault) begin
         value_in = 32'd0;
      end
   end

   // stage 3: result register
   logic        rsp_strobe_ff;
   logic [31:0] rsp_load_value_ff;
   logic        rsp_io_access_ff;
   logic        rsp_range_fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rd_ctrl_ff.valid;
      end
      rsp_load_value_ff  <= value_in;
      rsp_io_access_ff   <= rd_ctrl_ff.io;
      rsp_range_fault_ff <= rd_ctrl_ff.fault;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_load_value  = rsp_load_value_ff;
   assign rsp_io_access   = rsp_io_access_ff;
   assign rsp_range_fault = rsp_range_fault_ff;

   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3))
      else $error("result strobe without matching request");

   a_io_fault_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_io_access && rsp_range_fault))
      else $error("io access flagged as range fault");

   a_fault_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_range_fault || rsp_io_access)) |-> (rsp_load_value == 32'd0))
      else $error("non-memory access returned data");

   a_no_write_on_fault: assert property (@(posedge clock) disable iff (reset)
      (s1_fault || s1_io) |-> !(lane_we[0] || lane_we[1] || lane_we[2] || lane_we[3]))
      else $error("RAM written by faulting or io access");

endmodule
